/* src/vnef_pkg.sv */
// Shared types and constants of the voxel neighbourhood energy factor unit.
`default_nettype none
package vnef_pkg;

   localparam int UNIT_W = 64;   // shift register / result width of the serial unit
   localparam int DIV_W  = 48;   // divisor width
   localparam int ACC_W  = 48;   // weight accumulators
   localparam int STEP_W = 7;

   localparam logic [1:0] KIND_WRITE   = 2'd0;
   localparam logic [1:0] KIND_ADVANCE = 2'd1;
   localparam logic [1:0] KIND_QUERY   = 2'd2;

   localparam logic [7:0] CSR_RADIUS      = 8'd0;
   localparam logic [7:0] CSR_LAYERS_USED = 8'd1;
   localparam logic [7:0] CSR_Z_RATIO     = 8'd2;
   localparam logic [7:0] CSR_WIDTH_USED  = 8'd3;
   localparam logic [7:0] CSR_HEIGHT_USED = 8'd4;

   localparam logic [15:0] FACTOR_HALF = 16'd16384;
   localparam logic [6:0]  OCC_WEIGHT  = 7'd100;

   localparam logic [STEP_W-1:0] SQRT_STEPS  = 7'd12;
   localparam logic [STEP_W-1:0] RECIP_STEPS = 7'd33;
   localparam logic [STEP_W-1:0] FINAL_STEPS = 7'd64;

   typedef enum logic [0:0] {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic              start;
      unit_op_type       op;
      logic [STEP_W-1:0] steps;
   } unit_cmd_type;

endpackage
`default_nettype wire

/* src/vnef_ram.sv */
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module vnef_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/vnef_serial_unit.sv */
// Bit-serial restoring divider / square root sharing one compare-subtract.
`default_nettype none
module vnef_serial_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire vnef_pkg::unit_cmd_type      cmd,
   input  wire logic [vnef_pkg::UNIT_W-1:0] operand,
   input  wire logic [vnef_pkg::DIV_W-1:0]  divisor,
   output logic                             done,
   output logic [vnef_pkg::UNIT_W-1:0]      result
);
   import vnef_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   unit_op_type       op_ff, op_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [UNIT_W-1:0] sh_ff, sh_in, res_ff, res_in;
   logic [DIV_W:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]  dv_ff, dv_in;

   logic [DIV_W:0]    opa, opb, diff;
   logic [UNIT_W-1:0] sh_next;
   logic              ge;

   always_comb begin
      if (op_ff == OP_SQRT) begin
         opa     = {rem_ff[DIV_W-2:0], sh_ff[UNIT_W-1 -: 2]};
         opb     = {res_ff[DIV_W-2:0], 2'b01};
         sh_next = {sh_ff[UNIT_W-3:0], 2'b00};
      end else begin
         opa     = {rem_ff[DIV_W-1:0], sh_ff[UNIT_W-1]};
         opb     = {1'b0, dv_ff};
         sh_next = {sh_ff[UNIT_W-2:0], 1'b0};
      end
      ge   = opa >= opb;
      diff = opa - opb;
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      if (cmd.start) begin
         run_in = 1'b1;
         op_in  = cmd.op;
         cnt_in = cmd.steps;
         sh_in  = operand;
         res_in = '0;
         rem_in = '0;
         dv_in  = divisor;
      end else if (run_ff) begin
         rem_in = ge ? diff : opa;
         res_in = {res_ff[UNIT_W-2:0], ge};
         sh_in  = sh_next;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_DIV;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
      dv_ff  <= dv_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

/* src/voxel_neighbourhood_energy_factor_unit.sv */
// Top level of the voxel neighbourhood energy factor unit: sequencer, layer store, registers.
`default_nettype none
// Keeps MAX_LAYERS occupancy layers of GRID_Y rows by GRID_X cells in one RAM, one row
// per word. A command is taken when start is high and busy is low. kind 0 writes one cell
// of the newest layer (read-modify-write of its row). kind 1 advances the history and
// clears the new newest layer row by row. kind 2 queries a cell: an empty or out-of-grid
// cell answers 0.5; an occupied cell walks the neighbourhood ball, with 12 square-root
// steps and 33 reciprocal steps on the shared serial unit for each offset inside it, and
// a final 64-step normalizing division. That serial unit sets the query time. After
// reset the whole store is cleared with busy high; configuration writes are taken at any
// time. The single result of a query appears on rsp_factor / rsp_occupied for exactly
// one cycle with rsp_valid high and must be captured then: the receiver cannot stall the
// block. kind 3 is dropped.
module voxel_neighbourhood_energy_factor_unit #(
   parameter int GRID_X     = 64,
   parameter int GRID_Y     = 64,
   parameter int MAX_LAYERS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_kind,
   input  wire logic [5:0]  req_x,
   input  wire logic [5:0]  req_y,
   input  wire logic        req_cell_req,
   output logic             rsp_valid,
   output logic [15:0]      rsp_factor,
   output logic             rsp_occupied,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import vnef_pkg::*;

   localparam int DEPTH  = MAX_LAYERS * GRID_Y;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int XI_W   = $clog2(GRID_X);
   localparam int SLOT_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int TMP_W  = SLOT_W + 2;
   localparam logic [ADDR_W-1:0] ROWS_PER_LAYER = ADDR_W'(GRID_Y);

   typedef enum logic [14:0] {
      ST_CLEAR     = 15'h0001,
      ST_IDLE      = 15'h0002,
      ST_WR_RD     = 15'h0004,
      ST_WR_WB     = 15'h0008,
      ST_Q_RD      = 15'h0010,
      ST_Q_CHK     = 15'h0020,
      ST_LAYER     = 15'h0040,
      ST_LAYER_SQ  = 15'h0080,
      ST_OFF_EVAL  = 15'h0100,
      ST_OFF_TEST  = 15'h0200,
      ST_OFF_SQRT  = 15'h0400,
      ST_OFF_RECIP = 15'h0800,
      ST_FIN       = 15'h1000,
      ST_FIN_WAIT  = 15'h2000,
      ST_RESP      = 15'h4000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [3:0]  radius_ff, layers_ff;
   logic [11:0] zr_ff;
   logic [6:0]  wu_ff, hu_ff;

   // command latch
   logic [5:0]  x_ff, x_in, y_ff, y_in;
   logic        cell_ff, cell_in;

   // history
   logic [SLOT_W-1:0] newest_ff, newest_in, slot_ff, slot_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in, clr_end_ff, clr_end_in;

   // walk
   logic [4:0]  l_ff, l_in;
   logic [4:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [11:0] zl_ff, zl_in;
   logic [23:0] zz_ff, zz_in, lim_ff, lim_in;
   logic [25:0] d2_ff, d2_in;
   logic        keep_ff, keep_in, cell_ok_ff, cell_ok_in, cellbit_ff, cellbit_in;
   logic [XI_W-1:0] xi_ff, xi_in;
   logic [ACC_W-1:0] num_ff, num_in, den_ff, den_in;
   logic [15:0] factor_ff, factor_in;
   logic        occ_ff, occ_in;

   // store
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [GRID_X-1:0] wr_data, rd_data;

   // serial unit
   unit_cmd_type      ucmd;
   logic [UNIT_W-1:0] uoperand, uresult;
   logic [DIV_W-1:0]  udivisor;
   logic              udone;

   // combinational helpers
   logic [8:0]  eff_w, eff_h;
   logic [4:0]  lmax, r_pos, r_neg;
   logic        own_in_grid;
   logic [XI_W-1:0] own_xi;
   logic [ADDR_W-1:0] own_addr, off_addr;
   logic [9:0]  xx, yy;
   logic [3:0]  adx, ady;
   logic [8:0]  sq;
   logic [16:0] zl_full;
   logic [TMP_W-1:0] slot_tmp;
   logic [SLOT_W-1:0] slot_of_l, newest_next;
   logic [4:0]  adv_dx, adv_dy, adv_l;
   state_type   adv_state;
   logic [31:0] w_scaled;

   vnef_ram #(.WIDTH(GRID_X), .DEPTH(DEPTH)) u_layer_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vnef_serial_unit u_serial (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ucmd),
      .operand (uoperand),
      .divisor (udivisor),
      .done    (udone),
      .result  (uresult)
   );

   // configuration port: writes land in any state
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 4'd4;
         layers_ff <= 4'd4;
         zr_ff     <= 12'd256;
         wu_ff     <= 7'd64;
         hu_ff     <= 7'd64;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS:      radius_ff <= csr_data[3:0];
            CSR_LAYERS_USED: layers_ff <= csr_data[3:0];
            CSR_Z_RATIO:     zr_ff     <= csr_data[11:0];
            CSR_WIDTH_USED:  wu_ff     <= csr_data[6:0];
            CSR_HEIGHT_USED: hu_ff     <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_w = (9'(wu_ff) > 9'(GRID_X)) ? 9'(GRID_X) : 9'(wu_ff);
      eff_h = (9'(hu_ff) > 9'(GRID_Y)) ? 9'(GRID_Y) : 9'(hu_ff);
      lmax  = (5'(layers_ff) > 5'(MAX_LAYERS)) ? 5'(MAX_LAYERS) : 5'(layers_ff);
      r_pos = {1'b0, radius_ff};
      r_neg = 5'd0 - r_pos;

      own_in_grid = (9'(x_ff) < eff_w) && (9'(y_ff) < eff_h);
      own_xi      = XI_W'(x_ff);
      own_addr    = ADDR_W'(newest_ff) * ROWS_PER_LAYER + ADDR_W'(y_ff);

      // neighbour cell, two's complement coordinates
      xx       = {4'b0000, x_ff} + {{5{dx_ff[4]}}, dx_ff};
      yy       = {4'b0000, y_ff} + {{5{dy_ff[4]}}, dy_ff};
      off_addr = ADDR_W'(slot_ff) * ROWS_PER_LAYER + ADDR_W'(yy);

      adx = dx_ff[4] ? 4'(5'd0 - dx_ff) : dx_ff[3:0];
      ady = dy_ff[4] ? 4'(5'd0 - dy_ff) : dy_ff[3:0];
      sq  = 9'(adx) * 9'(adx) + 9'(ady) * 9'(ady);

      zl_full = 17'(zr_ff) * 17'(l_ff);

      // ring slot of layer l, counted back from the newest
      slot_tmp = TMP_W'(newest_ff) + TMP_W'(MAX_LAYERS) - TMP_W'(l_ff);
      if (slot_tmp >= TMP_W'(MAX_LAYERS)) begin
         slot_tmp = slot_tmp - TMP_W'(MAX_LAYERS);
      end
      slot_of_l = SLOT_W'(slot_tmp);

      newest_next = (newest_ff == SLOT_W'(MAX_LAYERS - 1)) ? '0 : newest_ff + 1'b1;

      // offset walk order: dx fastest, then dy, then layer
      adv_dx    = r_neg;
      adv_dy    = dy_ff;
      adv_l     = l_ff;
      adv_state = ST_OFF_EVAL;
      if (dx_ff != r_pos) begin
         adv_dx = dx_ff + 5'd1;
      end else if (dy_ff != r_pos) begin
         adv_dy = dy_ff + 5'd1;
      end else begin
         adv_dy    = r_neg;
         adv_l     = l_ff + 5'd1;
         adv_state = ST_LAYER;
      end

      w_scaled = 32'(uresult[24:0]) * 32'(OCC_WEIGHT);
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      cell_in     = cell_ff;
      newest_in   = newest_ff;
      slot_in     = slot_ff;
      clr_addr_in = clr_addr_ff;
      clr_end_in  = clr_end_ff;
      l_in        = l_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      zl_in       = zl_ff;
      zz_in       = zz_ff;
      lim_in      = lim_ff;
      d2_in       = d2_ff;
      keep_in     = keep_ff;
      cell_ok_in  = cell_ok_ff;
      cellbit_in  = cellbit_ff;
      xi_in       = xi_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      factor_in   = factor_ff;
      occ_in      = occ_ff;

      wr_en    = 1'b0;
      wr_addr  = own_addr;
      wr_data  = rd_data;
      rd_addr  = (state_ff == ST_OFF_EVAL) ? off_addr : own_addr;

      ucmd     = '{start: 1'b0, op: OP_DIV, steps: FINAL_STEPS};
      uoperand = '0;
      udivisor = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == clr_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               x_in    = req_x;
               y_in    = req_y;
               cell_in = req_cell_req;
               case (req_kind)
                  KIND_WRITE: state_in = ST_WR_RD;
                  KIND_ADVANCE: begin
                     newest_in   = newest_next;
                     clr_addr_in = ADDR_W'(newest_next) * ROWS_PER_LAYER;
                     clr_end_in  = ADDR_W'(newest_next) * ROWS_PER_LAYER
                                   + ROWS_PER_LAYER - 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  KIND_QUERY: state_in = ST_Q_RD;
                  default: ;
               endcase
            end
         end
         ST_WR_RD: begin
            state_in = own_in_grid ? ST_WR_WB : ST_IDLE;
         end
         ST_WR_WB: begin
            wr_en           = 1'b1;
            wr_data[own_xi] = cell_ff;
            state_in        = ST_IDLE;
         end
         ST_Q_RD: begin
            state_in = ST_Q_CHK;
         end
         ST_Q_CHK: begin
            occ_in = own_in_grid && rd_data[own_xi];
            if (own_in_grid && rd_data[own_xi]) begin
               num_in   = '0;
               den_in   = '0;
               l_in     = '0;
               dx_in    = r_neg;
               dy_in    = r_neg;
               lim_in   = {8'(radius_ff) * 8'(radius_ff), 16'd0};
               state_in = ST_LAYER;
            end else begin
               factor_in = FACTOR_HALF;
               state_in  = ST_RESP;
            end
         end
         ST_LAYER: begin
            // layers stop at the layer count or at the first one past the ball
            if ((l_ff < lmax) && (zl_full <= 17'({radius_ff, 8'd0}))) begin
               zl_in    = zl_full[11:0];
               slot_in  = slot_of_l;
               state_in = ST_LAYER_SQ;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_LAYER_SQ: begin
            zz_in    = 24'(zl_ff) * 24'(zl_ff);
            state_in = ST_OFF_EVAL;
         end
         ST_OFF_EVAL: begin
            d2_in      = {1'b0, sq, 16'd0} + 26'(zz_ff);
            keep_in    = !((dx_ff == 5'd0) && (dy_ff == 5'd0))
                         && (({1'b0, sq, 16'd0} + 26'(zz_ff)) <= 26'(lim_ff));
            cell_ok_in = !xx[9] && !yy[9] && (xx < 10'(eff_w)) && (yy < 10'(eff_h));
            xi_in      = XI_W'(xx);
            state_in   = ST_OFF_TEST;
         end
         ST_OFF_TEST: begin
            cellbit_in = cell_ok_ff && rd_data[xi_ff];
            if (keep_ff) begin
               ucmd     = '{start: 1'b1, op: OP_SQRT, steps: SQRT_STEPS};
               uoperand = {d2_ff[23:0], 40'd0};
               state_in = ST_OFF_SQRT;
            end else begin
               dx_in    = adv_dx;
               dy_in    = adv_dy;
               l_in     = adv_l;
               state_in = adv_state;
            end
         end
         ST_OFF_SQRT: begin
            if (udone) begin
               // w = 2^32 / s
               ucmd     = '{start: 1'b1, op: OP_DIV, steps: RECIP_STEPS};
               uoperand = {1'b1, 63'd0};
               udivisor = DIV_W'(uresult[11:0]);
               state_in = ST_OFF_RECIP;
            end
         end
         ST_OFF_RECIP: begin
            if (udone) begin
               num_in   = num_ff + (cellbit_ff ? ACC_W'(w_scaled) : ACC_W'(uresult[24:0]));
               den_in   = den_ff + ACC_W'(w_scaled);
               dx_in    = adv_dx;
               dy_in    = adv_dy;
               l_in     = adv_l;
               state_in = adv_state;
            end
         end
         ST_FIN: begin
            if (den_ff == '0) begin
               factor_in = FACTOR_HALF;
               state_in  = ST_RESP;
            end else begin
               ucmd     = '{start: 1'b1, op: OP_DIV, steps: FINAL_STEPS};
               uoperand = {1'b0, num_ff[ACC_W-1:0], 15'd0} + UNIT_W'(den_ff >> 1);
               udivisor = den_ff;
               state_in = ST_FIN_WAIT;
            end
         end
         ST_FIN_WAIT: begin
            if (udone) begin
               factor_in = uresult[15:0];
               state_in  = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         newest_ff   <= '0;
         clr_addr_ff <= '0;
         clr_end_ff  <= ADDR_W'(DEPTH - 1);
      end else begin
         state_ff    <= state_in;
         newest_ff   <= newest_in;
         clr_addr_ff <= clr_addr_in;
         clr_end_ff  <= clr_end_in;
      end
      x_ff       <= x_in;
      y_ff       <= y_in;
      cell_ff    <= cell_in;
      slot_ff    <= slot_in;
      l_ff       <= l_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      zl_ff      <= zl_in;
      zz_ff      <= zz_in;
      lim_ff     <= lim_in;
      d2_ff      <= d2_in;
      keep_ff    <= keep_in;
      cell_ok_ff <= cell_ok_in;
      cellbit_ff <= cellbit_in;
      xi_ff      <= xi_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      factor_ff  <= factor_in;
      occ_ff     <= occ_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = (state_ff == ST_RESP);
   assign rsp_factor   = factor_ff;
   assign rsp_occupied = occ_ff;

   // one strobe per query, never two in a row
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_factor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_factor <= 16'd32768))
      else $error("factor above 1.0");

   a_empty_half: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_occupied) |-> (rsp_factor == FACTOR_HALF))
      else $error("empty cell did not return 0.5");

   a_cmd_takes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == KIND_WRITE || req_kind == KIND_ADVANCE
                          || req_kind == KIND_QUERY)) |=> busy)
      else $error("accepted command left the block idle");

endmodule
`default_nettype wire

/* dv/voxel_neighbourhood_energy_factor_unit_tb.sv */
// Self-checking testbench of the voxel neighbourhood energy factor unit.
`timescale 1ns / 100ps
module voxel_neighbourhood_energy_factor_unit_tb;
   import vnef_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;   // dropped by the block, no result
   localparam int NUM_LAYERS = 8;
   localparam int GRID = 64;
   localparam int IDLE_LIMIT = 200000;          // cycles with no transfer at all
   localparam int SETTLE = 70;                  // covers an advance

   typedef struct packed {
      logic [15:0] factor;
      logic        occupied;
   } energy_type;

   // one directed step: a register set (cfg >= 0) or one command
   typedef struct {
      int          cfg;
      logic [1:0]  kind;
      logic [5:0]  x;
      logic [5:0]  y;
      logic        occ_bit;
      bit          typed;
      logic [15:0] factor;
      logic        occupied;
   } step_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [5:0]  req_x;
   logic [5:0]  req_y;
   logic        req_cell_req;
   logic        rsp_valid;
   logic [15:0] rsp_factor;
   logic        rsp_occupied;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   voxel_neighbourhood_energy_factor_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_kind     (req_kind),
      .req_x        (req_x),
      .req_y        (req_y),
      .req_cell_req (req_cell_req),
      .rsp_valid    (rsp_valid),
      .rsp_factor   (rsp_factor),
      .rsp_occupied (rsp_occupied),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow of the block: occupancy history and register copies.
   // ---------------------------------------------------------------------
   bit          occ_map [NUM_LAYERS][GRID][GRID];
   int          newest_slot;
   logic [3:0]  sh_radius;
   logic [3:0]  sh_layers;
   logic [11:0] sh_z;
   logic [6:0]  sh_width;
   logic [6:0]  sh_height;

   energy_type  factor_q[$];    // results still owed by the block
   int          mismatches;
   int          idle_cycles;
   int          burst_left;

   function automatic int grid_w();
      return (sh_width > GRID) ? GRID : int'(sh_width);
   endfunction

   function automatic int grid_h();
      return (sh_height > GRID) ? GRID : int'(sh_height);
   endfunction

   // layer 0 is the newest; anything off the active grid reads empty
   function automatic bit cell_at(int lay, int cx, int cy);
      int slot;
      if (cx < 0 || cy < 0 || cx >= grid_w() || cy >= grid_h())
         return 1'b0;
      slot = (newest_slot + NUM_LAYERS - (lay % NUM_LAYERS)) % NUM_LAYERS;
      return occ_map[slot][cy][cx];
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res;
      longint unsigned one;
      res = 0;
      one = 64'd1 << 62;
      while (one > v) one = one >> 2;
      while (one != 0) begin
         if (v >= res + one) begin
            v = v - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction

   // inverse-distance weighted occupancy over the ball, 1.15 rounded
   function automatic logic [15:0] predict_factor(int cx, int cy);
      longint unsigned num, den, lim, zz, d2, w;
      int r, lmax, lay, dx, dy;
      num  = 0;
      den  = 0;
      r    = sh_radius;
      lmax = (sh_layers > NUM_LAYERS) ? NUM_LAYERS : int'(sh_layers);
      lim  = longint'(r) * r * 65536;
      for (lay = 0; lay < lmax && longint'(r) * 256 >= longint'(lay) * sh_z; lay++) begin
         zz = longint'(sh_z) * lay;
         zz = zz * zz;
         for (dy = -r; dy <= r; dy++) begin
            for (dx = -r; dx <= r; dx++) begin
               if (dx == 0 && dy == 0) continue;
               d2 = longint'(dx * dx + dy * dy) * 65536 + zz;
               if (d2 > lim) continue;
               w = (64'd1 << 32) / int_root(d2);
               num += cell_at(lay, cx + dx, cy + dy) ? 100 * w : w;
               den += 100 * w;
            end
         end
      end
      if (den == 0)
         return FACTOR_HALF;
      return 16'((num * 32768 + den / 2) / den);
   endfunction

   // apply one accepted command to the shadow; returns 1 when a result is owed
   function automatic bit apply_command(logic [1:0] kind, int cx, int cy, bit occ_bit,
                                        output energy_type res);
      res = '0;
      case (kind)
         KIND_WRITE: begin
            if (cx < grid_w() && cy < grid_h())
               occ_map[newest_slot][cy][cx] = occ_bit;
         end
         KIND_ADVANCE: begin
            newest_slot = (newest_slot + 1) % NUM_LAYERS;
            for (int i = 0; i < GRID; i++)
               for (int j = 0; j < GRID; j++)
                  occ_map[newest_slot][i][j] = 1'b0;
         end
         KIND_QUERY: begin
            res.occupied = cell_at(0, cx, cy);
            res.factor   = res.occupied ? predict_factor(cx, cy) : FACTOR_HALF;
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Command side. Start stays high across a burst; a gap lowers it.
   // ---------------------------------------------------------------------
   task automatic send_command(logic [1:0] kind, logic [5:0] cx, logic [5:0] cy,
                               logic occ_bit, bit typed = 1'b0,
                               logic [15:0] t_factor = '0, logic t_occ = 1'b0);
      energy_type res;
      start        <= 1'b1;
      req_kind     <= kind;
      req_x        <= cx;
      req_y        <= cy;
      req_cell_req <= occ_bit;
      @(posedge clock);
      while (busy) @(posedge clock);
      // transfer taken at this edge
      if (apply_command(kind, cx, cy, occ_bit, res)) begin
         if (typed) begin
            res.factor   = t_factor;
            res.occupied = t_occ;
         end
         factor_q.insert(factor_q.size(), res);
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         // now and then a long stretch with no gaps
         burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 8);
      end
   endtask

   // drop start, wait for every owed result and for the block to settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (factor_q.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one register transfer; valid is left high for the next one
   task automatic csr_put(logic [7:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_RADIUS:      sh_radius = data[3:0];
         CSR_LAYERS_USED: sh_layers = data[3:0];
         CSR_Z_RATIO:     sh_z      = data[11:0];
         CSR_WIDTH_USED:  sh_width  = data[6:0];
         CSR_HEIGHT_USED: sh_height = data[6:0];
         default: ;
      endcase
   endtask

   // write all five registers while idle; junk above each field width is ignored
   task automatic set_regs(int rad, int lay, int z, int wid, int hgt, bit junk);
      drain();
      csr_put(CSR_RADIUS,      16'(rad) | (junk ? 16'($urandom) & 16'hFFF0 : 16'h0));
      csr_put(CSR_LAYERS_USED, 16'(lay) | (junk ? 16'($urandom) & 16'hFFF0 : 16'h0));
      csr_put(CSR_Z_RATIO,     16'(z)   | (junk ? 16'($urandom) & 16'hF000 : 16'h0));
      csr_put(CSR_WIDTH_USED,  16'(wid) | (junk ? 16'($urandom) & 16'hFF80 : 16'h0));
      csr_put(CSR_HEIGHT_USED, 16'(hgt) | (junk ? 16'($urandom) & 16'hFF80 : 16'h0));
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Result side: every strobe must match the oldest owed result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      energy_type want;
      if (!reset && rsp_valid) begin
         if (factor_q.size() == 0) begin
            $error("unexpected result: factor %0d occupied %0b", rsp_factor, rsp_occupied);
            mismatches++;
         end else begin
            want = factor_q.pop_front();
            if (rsp_factor !== want.factor) begin
               $error("factor: expected %0d, got %0d", want.factor, rsp_factor);
               mismatches++;
            end
            if (rsp_occupied !== want.occupied) begin
               $error("occupied: expected %0b, got %0b", want.occupied, rsp_occupied);
               mismatches++;
            end
         end
      end
   end

   // watchdog: any transfer on any port counts as progress
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Directed table. Register sets listed in reg_sets, referenced by cfg.
   // ---------------------------------------------------------------------
   int reg_sets [6][5] = '{
      '{0, 1, 256, 64, 64},      // empty ball
      '{1, 1, 256, 64, 64},      // nearest ring only
      '{1, 1, 256, 2, 64},       // narrow grid
      '{1, 1, 256, 127, 127},    // sizes above the grid clamp
      '{2, 15, 0, 64, 64},       // layer count clamp, no vertical distance
      '{15, 8, 4095, 64, 64}     // widest ball, thickest layers
   };

   function automatic step_row_type cmd(logic [1:0] kind, int cx, int cy, bit occ_bit,
                                        bit typed = 0, int f = 0, bit o = 0);
      step_row_type row;
      row = '{-1, kind, 6'(cx), 6'(cy), occ_bit, typed, 16'(f), o};
      return row;
   endfunction

   function automatic step_row_type cfg(int idx);
      step_row_type row;
      row = cmd(KIND_WRITE, 0, 0, 0);
      row.cfg = idx;
      return row;
   endfunction

   step_row_type directed[$];

   function automatic void add_row(step_row_type row);
      directed.insert(directed.size(), row);
   endfunction

   initial begin
      int ax, ay, cx, cy, pick, rad, lay, z, wid, hgt;

      reset        <= 1'b1;
      start        <= 1'b0;
      req_kind     <= KIND_WRITE;
      req_x        <= '0;
      req_y        <= '0;
      req_cell_req <= 1'b0;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      mismatches   = 0;
      idle_cycles  = 0;
      burst_left   = 0;
      newest_slot  = 0;
      sh_radius    = 4;
      sh_layers    = 4;
      sh_z         = 256;
      sh_width     = 64;
      sh_height    = 64;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // a query right after reset sees the cleared store
      add_row(cmd(KIND_QUERY, 0, 0, 0, 1, 16384, 0));
      add_row(cfg(0));
      add_row(cmd(KIND_WRITE, 63, 63, 1));
      add_row(cmd(KIND_QUERY, 63, 63, 0, 1, 16384, 1));
      add_row(cfg(1));
      // lone corner cell: all neighbours empty, 32768 / 100 rounded
      add_row(cmd(KIND_QUERY, 63, 63, 0, 1, 328, 1));
      for (int j = 0; j < 3; j++)
         for (int i = 0; i < 3; i++)
            add_row(cmd(KIND_WRITE, i, j, 1));
      // fully occupied ring gives exactly 1.0
      add_row(cmd(KIND_QUERY, 1, 1, 0, 1, 32768, 1));
      add_row(cmd(KIND_WRITE, 1, 1, 0));
      add_row(cmd(KIND_QUERY, 1, 1, 0, 1, 16384, 0));
      add_row(cfg(2));
      // cell written earlier but now off the grid
      add_row(cmd(KIND_QUERY, 2, 2, 0, 1, 16384, 0));
      add_row(cmd(KIND_WRITE, 5, 5, 1));
      add_row(cfg(3));
      add_row(cmd(KIND_QUERY, 5, 5, 0, 1, 16384, 0));
      add_row(cmd(KIND_ADVANCE, 0, 0, 0));
      add_row(cmd(KIND_QUERY, 63, 63, 0, 1, 16384, 0));
      add_row(cmd(KIND_UNUSED, 63, 63, 1));
      add_row(cfg(4));
      add_row(cmd(KIND_WRITE, 2, 1, 1));
      add_row(cmd(KIND_QUERY, 2, 1, 0));
      add_row(cfg(5));
      add_row(cmd(KIND_WRITE, 32, 32, 1));
      add_row(cmd(KIND_QUERY, 32, 32, 0));

      foreach (directed[k]) begin
         if (directed[k].cfg >= 0) begin
            set_regs(reg_sets[directed[k].cfg][0], reg_sets[directed[k].cfg][1],
                     reg_sets[directed[k].cfg][2], reg_sets[directed[k].cfg][3],
                     reg_sets[directed[k].cfg][4], 1'b0);
         end else begin
            send_command(directed[k].kind, directed[k].x, directed[k].y,
                         directed[k].occ_bit, directed[k].typed, directed[k].factor,
                         directed[k].occupied);
         end
      end

      // unmapped register index: must change nothing
      drain();
      csr_put(8'hFF, 16'hFFFF);
      csr_valid <= 1'b0;

      // random phases; small balls keep occupied queries short
      for (int phase = 0; phase < 8; phase++) begin
         rad = (phase == 3) ? 3 : $urandom_range(1, 2);
         lay = (phase == 3) ? $urandom_range(1, 2) : (phase == 5) ? 15 :
               (phase == 6) ? 0 : $urandom_range(1, 8);
         pick = $urandom_range(0, 3);
         z   = (pick == 0) ? 0 : (pick == 1) ? 4095 :
               (pick == 2) ? $urandom_range(1, 512) : $urandom_range(1, 4095);
         wid = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 127) : 64;
         hgt = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 127) : 64;
         set_regs(rad, lay, z, wid, hgt, 1'b1);
         ax = $urandom_range(0, 63);
         ay = $urandom_range(0, 63);
         for (int n = 0; n < 70; n++) begin
            // mostly a dense patch around the anchor, some anywhere
            if ($urandom_range(0, 4) != 0) begin
               cx = ax + $urandom_range(0, 4) - 2;
               cy = ay + $urandom_range(0, 4) - 2;
               cx = (cx < 0) ? 0 : (cx > 63) ? 63 : cx;
               cy = (cy < 0) ? 0 : (cy > 63) ? 63 : cy;
            end else begin
               cx = $urandom_range(0, 63);
               cy = $urandom_range(0, 63);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
               send_command(KIND_WRITE, 6'(cx), 6'(cy), $urandom_range(0, 9) < 7);
            else if (pick < 60)
               send_command(KIND_ADVANCE, 6'(cx), 6'(cy), 1'($urandom));
            else if (pick < 95)
               send_command(KIND_QUERY, 6'(cx), 6'(cy), 1'($urandom));
            else
               send_command(KIND_UNUSED, 6'(cx), 6'(cy), 1'($urandom));
            // hold off once mid-phase until everything owed has come back
            if (phase == 2 && n == 35)
               drain();
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (factor_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

/* sim.f */
src/vnef_pkg.sv
src/vnef_ram.sv
src/vnef_serial_unit.sv
src/voxel_neighbourhood_energy_factor_unit.sv
dv/voxel_neighbourhood_energy_factor_unit_tb.sv
